FILE: src/vsc_pkg.sv
// shared types and constants of the voxel shape carver
// no dependencies; the top level, vsc_coef and vsc_scan refer to this package
package vsc_pkg;

    // width of one box bound or scan index field
    localparam int IDXW = 8;
    // squared coordinate offset, weight, weight low half, product and accumulator widths
    localparam int SQW = 20;
    localparam int WW  = 37;
    localparam int BLO = 19;
    localparam int MW  = 57;
    localparam int SW  = 60;
    // configuration index width
    localparam int CFG_IDXW = 4;

    // command opcodes
    localparam logic [3:0] OP_PUT_VOXEL  = 4'd0;
    localparam logic [3:0] OP_CUT_VOXEL  = 4'd1;
    localparam logic [3:0] OP_PUT_BOX    = 4'd2;
    localparam logic [3:0] OP_CUT_BOX    = 4'd3;
    localparam logic [3:0] OP_PUT_SPHERE = 4'd4;
    localparam logic [3:0] OP_CUT_SPHERE = 4'd5;
    localparam logic [3:0] OP_PUT_ELLIP  = 4'd6;
    localparam logic [3:0] OP_CUT_ELLIP  = 4'd7;
    localparam logic [3:0] OP_READ_VOXEL = 4'd8;

    // configuration register indexes
    localparam logic [CFG_IDXW-1:0] REG_RED   = 4'd0;
    localparam logic [CFG_IDXW-1:0] REG_GREEN = 4'd1;
    localparam logic [CFG_IDXW-1:0] REG_BLUE  = 4'd2;
    localparam logic [CFG_IDXW-1:0] REG_ALPHA = 4'd3;

    // top level sequencer states
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_CLEAR_WAIT,
        ST_IDLE,
        ST_COEF_GO,
        ST_COEF_WAIT,
        ST_SCAN_GO,
        ST_SCAN_WAIT,
        ST_READ_ADDR,
        ST_READ_DATA,
        ST_RESP
    } state_t;

    // one scan job: inclusive index ranges and what to write
    typedef struct packed {
        logic [IDXW-1:0] xlo;
        logic [IDXW-1:0] xhi;
        logic [IDXW-1:0] ylo;
        logic [IDXW-1:0] yhi;
        logic [IDXW-1:0] zlo;
        logic [IDXW-1:0] zhi;
        logic            test;
        logic            put;
        logic            clear;
    } scan_cmd_t;

    // forward difference seeds of the shape test, per axis at index 0
    typedef struct packed {
        logic signed [SW-1:0] lim;
        logic signed [SW-1:0] sx0;
        logic signed [SW-1:0] dx0;
        logic signed [SW-1:0] twx;
        logic signed [SW-1:0] sy0;
        logic signed [SW-1:0] dy0;
        logic signed [SW-1:0] twy;
        logic signed [SW-1:0] sz0;
        logic signed [SW-1:0] dz0;
        logic signed [SW-1:0] twz;
    } coef_t;

endpackage

FILE: src/voxel_shape_carver_unit.sv
// top level of the voxel shape carver: command decode, sequencing, store
// memories, configuration and output register; uses vsc_pkg, vsc_ram,
// vsc_coef and vsc_scan
//
// Commands enter on the s_axis channel, one word per command, and every
// command returns one word on the m_axis channel. Draw color registers are
// written through the cfg channel, which is always ready.
// After reset the store is swept clear, one voxel a cycle; s_axis_tready
// stays low until the sweep is done.
// A command is accepted only while the unit is idle. Voxel and box
// commands scan the single voxel or the clipped box; sphere and ellipsoid
// commands run the coefficient unit, then scan the whole grid, one voxel a
// cycle through the store write port; read voxel goes through the
// registered read port; skipped commands (voxel or read outside the grid,
// empty box, zero ellipsoid radius, unknown opcode) go straight to the result.
// The result waits in an output register; a stalled receiver does not block
// the next command, but a finished result waits until the register is free.
module voxel_shape_carver_unit #(
    parameter int GRID_X = 32,
    parameter int GRID_Y = 32,
    parameter int GRID_Z = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // command word, fields from bit 0: opcode, first_x, first_y, first_z,
    // second_x, second_y, second_z
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [63:0]                   s_axis_tdata,
    // result word, fields from bit 0: out_of_range, bad_radius, voxel_on,
    // voxel_red, voxel_green, voxel_blue, voxel_alpha, zero fill
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [39:0]                   m_axis_tdata,
    // draw color register writes
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [vsc_pkg::CFG_IDXW-1:0]  cfg_index,
    input  logic [7:0]                    cfg_data
);

    localparam int DEPTH = GRID_X * GRID_Y * GRID_Z;
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int XW = (GRID_X > 1) ? $clog2(GRID_X) : 1;
    localparam int YW = (GRID_Y > 1) ? $clog2(GRID_Y) : 1;
    localparam int ZW = (GRID_Z > 1) ? $clog2(GRID_Z) : 1;
    localparam int YZ = GRID_Y * GRID_Z;
    localparam int IDXW = vsc_pkg::IDXW;
    localparam logic signed [10:0] GXM = 11'(GRID_X - 1);
    localparam logic signed [10:0] GYM = 11'(GRID_Y - 1);
    localparam logic signed [10:0] GZM = 11'(GRID_Z - 1);

    vsc_pkg::state_t    state_reg, state_next;
    vsc_pkg::scan_cmd_t cmd_reg, cmd_next;
    vsc_pkg::coef_t     coef;

    logic [7:0]        red_reg, green_reg, blue_reg, alpha_reg;
    logic              out_valid_reg;
    logic [39:0]       out_data_reg;
    logic              res_oor_reg, res_badr_reg, res_on_reg;
    logic [31:0]       res_color_reg;
    logic [AW-1:0]     rd_addr_reg;
    logic signed [9:0] ax_reg, ay_reg, az_reg, bx_reg, by_reg, bz_reg;
    logic              sphere_reg;

    logic              in_acc, out_load;
    logic              coef_start, coef_done, scan_start, scan_done;
    logic              we_on, we_col, on_wdata, on_rdata;
    logic [AW-1:0]     waddr;
    logic [31:0]       col_wdata, col_rdata;

    logic [3:0]         op;
    logic signed [9:0]  fx, fy, fz, sx, sy, sz;
    logic signed [10:0] fx1, fy1, fz1, sx1, sy1, sz1;
    logic signed [10:0] xlo_c, xhi_c, ylo_c, yhi_c, zlo_c, zhi_c;
    logic               in_a, in_b, box_order, clip_ok, zero_rad;
    logic               is_voxel, is_box, is_shape, is_ellip, is_sphere, is_read;
    logic               oor_calc;
    logic [AW-1:0]      rd_addr_calc;

    // command field decode
    assign op  = s_axis_tdata[3:0];
    assign fx  = $signed(s_axis_tdata[13:4]);
    assign fy  = $signed(s_axis_tdata[23:14]);
    assign fz  = $signed(s_axis_tdata[33:24]);
    assign sx  = $signed(s_axis_tdata[43:34]);
    assign sy  = $signed(s_axis_tdata[53:44]);
    assign sz  = $signed(s_axis_tdata[63:54]);
    assign fx1 = {fx[9], fx};
    assign fy1 = {fy[9], fy};
    assign fz1 = {fz[9], fz};
    assign sx1 = {sx[9], sx};
    assign sy1 = {sy[9], sy};
    assign sz1 = {sz[9], sz};

    assign is_voxel  = (op == vsc_pkg::OP_PUT_VOXEL) || (op == vsc_pkg::OP_CUT_VOXEL);
    assign is_box    = (op == vsc_pkg::OP_PUT_BOX) || (op == vsc_pkg::OP_CUT_BOX);
    assign is_sphere = (op == vsc_pkg::OP_PUT_SPHERE) || (op == vsc_pkg::OP_CUT_SPHERE);
    assign is_ellip  = (op == vsc_pkg::OP_PUT_ELLIP) || (op == vsc_pkg::OP_CUT_ELLIP);
    assign is_shape  = is_sphere || is_ellip;
    assign is_read   = (op == vsc_pkg::OP_READ_VOXEL);

    // grid bounds checks and box clipping
    assign in_a = (fx1 >= 0) && (fx1 <= GXM) && (fy1 >= 0) && (fy1 <= GYM)
               && (fz1 >= 0) && (fz1 <= GZM);
    assign in_b = (sx1 >= 0) && (sx1 <= GXM) && (sy1 >= 0) && (sy1 <= GYM)
               && (sz1 >= 0) && (sz1 <= GZM);
    assign box_order = (fx1 <= sx1) && (fy1 <= sy1) && (fz1 <= sz1);
    assign xlo_c = (fx1 < 0) ? 11'sd0 : fx1;
    assign ylo_c = (fy1 < 0) ? 11'sd0 : fy1;
    assign zlo_c = (fz1 < 0) ? 11'sd0 : fz1;
    assign xhi_c = (sx1 > GXM) ? GXM : sx1;
    assign yhi_c = (sy1 > GYM) ? GYM : sy1;
    assign zhi_c = (sz1 > GZM) ? GZM : sz1;
    assign clip_ok  = (xlo_c <= xhi_c) && (ylo_c <= yhi_c) && (zlo_c <= zhi_c);
    assign zero_rad = (sx == 10'sd0) || (sy == 10'sd0) || (sz == 10'sd0);

    assign oor_calc = ((is_voxel || is_read) && !in_a)
                   || (is_box && box_order && (!in_a || !in_b));

    assign rd_addr_calc = AW'(fx[XW-1:0]) * AW'(YZ) + AW'(fy[YW-1:0]) * AW'(GRID_Z)
                        + AW'(fz[ZW-1:0]);

    // scan job for the command word
    always_comb
    begin
        cmd_next.put   = ~op[0];
        cmd_next.clear = 1'b0;
        cmd_next.test  = is_shape;
        if (is_shape)
        begin
            cmd_next.xlo = '0;
            cmd_next.ylo = '0;
            cmd_next.zlo = '0;
            cmd_next.xhi = IDXW'(GRID_X - 1);
            cmd_next.yhi = IDXW'(GRID_Y - 1);
            cmd_next.zhi = IDXW'(GRID_Z - 1);
        end
        else if (is_voxel)
        begin
            cmd_next.xlo = fx[IDXW-1:0];
            cmd_next.ylo = fy[IDXW-1:0];
            cmd_next.zlo = fz[IDXW-1:0];
            cmd_next.xhi = fx[IDXW-1:0];
            cmd_next.yhi = fy[IDXW-1:0];
            cmd_next.zhi = fz[IDXW-1:0];
        end
        else
        begin
            cmd_next.xlo = xlo_c[IDXW-1:0];
            cmd_next.ylo = ylo_c[IDXW-1:0];
            cmd_next.zlo = zlo_c[IDXW-1:0];
            cmd_next.xhi = xhi_c[IDXW-1:0];
            cmd_next.yhi = yhi_c[IDXW-1:0];
            cmd_next.zhi = zhi_c[IDXW-1:0];
        end
    end

    // handshakes
    assign s_axis_tready = (state_reg == vsc_pkg::ST_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_load      = (state_reg == vsc_pkg::ST_RESP) && (!out_valid_reg || m_axis_tready);
    assign cfg_ready     = 1'b1;
    assign coef_start    = (state_reg == vsc_pkg::ST_COEF_GO);
    assign scan_start    = (state_reg == vsc_pkg::ST_SCAN_GO)
                        || (state_reg == vsc_pkg::ST_CLEAR);

    // sequencer state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= vsc_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            vsc_pkg::ST_CLEAR:      state_next = vsc_pkg::ST_CLEAR_WAIT;
            vsc_pkg::ST_CLEAR_WAIT:
            begin
                if (scan_done)
                begin
                    state_next = vsc_pkg::ST_IDLE;
                end
            end
            vsc_pkg::ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    priority if (is_voxel)
                    begin
                        state_next = in_a ? vsc_pkg::ST_SCAN_GO : vsc_pkg::ST_RESP;
                    end
                    else if (is_box)
                    begin
                        state_next = (box_order && clip_ok) ? vsc_pkg::ST_SCAN_GO
                                                            : vsc_pkg::ST_RESP;
                    end
                    else if (is_sphere)
                    begin
                        state_next = vsc_pkg::ST_COEF_GO;
                    end
                    else if (is_ellip)
                    begin
                        state_next = zero_rad ? vsc_pkg::ST_RESP : vsc_pkg::ST_COEF_GO;
                    end
                    else if (is_read)
                    begin
                        state_next = in_a ? vsc_pkg::ST_READ_ADDR : vsc_pkg::ST_RESP;
                    end
                    else
                    begin
                        state_next = vsc_pkg::ST_RESP;
                    end
                end
            end
            vsc_pkg::ST_COEF_GO:    state_next = vsc_pkg::ST_COEF_WAIT;
            vsc_pkg::ST_COEF_WAIT:
            begin
                if (coef_done)
                begin
                    state_next = vsc_pkg::ST_SCAN_GO;
                end
            end
            vsc_pkg::ST_SCAN_GO:    state_next = vsc_pkg::ST_SCAN_WAIT;
            vsc_pkg::ST_SCAN_WAIT:
            begin
                if (scan_done)
                begin
                    state_next = vsc_pkg::ST_RESP;
                end
            end
            vsc_pkg::ST_READ_ADDR:  state_next = vsc_pkg::ST_READ_DATA;
            vsc_pkg::ST_READ_DATA:  state_next = vsc_pkg::ST_RESP;
            vsc_pkg::ST_RESP:
            begin
                if (out_load)
                begin
                    state_next = vsc_pkg::ST_IDLE;
                end
            end
            default:                state_next = vsc_pkg::ST_IDLE;
        endcase
    end

    // control registers: scan job, draw color, output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_reg.xlo   <= '0;
            cmd_reg.ylo   <= '0;
            cmd_reg.zlo   <= '0;
            cmd_reg.xhi   <= IDXW'(GRID_X - 1);
            cmd_reg.yhi   <= IDXW'(GRID_Y - 1);
            cmd_reg.zhi   <= IDXW'(GRID_Z - 1);
            cmd_reg.test  <= 1'b0;
            cmd_reg.put   <= 1'b0;
            cmd_reg.clear <= 1'b1;
            red_reg       <= 8'd0;
            green_reg     <= 8'd0;
            blue_reg      <= 8'd0;
            alpha_reg     <= 8'd255;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_acc)
            begin
                cmd_reg <= cmd_next;
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    vsc_pkg::REG_RED:   red_reg   <= cfg_data;
                    vsc_pkg::REG_GREEN: green_reg <= cfg_data;
                    vsc_pkg::REG_BLUE:  blue_reg  <= cfg_data;
                    vsc_pkg::REG_ALPHA: alpha_reg <= cfg_data;
                    default:            red_reg   <= red_reg;
                endcase
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // command operands and result fields
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            ax_reg        <= fx;
            ay_reg        <= fy;
            az_reg        <= fz;
            bx_reg        <= sx;
            by_reg        <= sy;
            bz_reg        <= sz;
            sphere_reg    <= is_sphere;
            rd_addr_reg   <= rd_addr_calc;
            res_oor_reg   <= oor_calc;
            res_badr_reg  <= is_ellip && zero_rad;
            res_on_reg    <= 1'b0;
            res_color_reg <= '0;
        end
        else if (state_reg == vsc_pkg::ST_READ_DATA)
        begin
            res_on_reg    <= on_rdata;
            res_color_reg <= col_rdata;
        end
        if (out_load)
        begin
            out_data_reg <= {5'd0, res_color_reg, res_on_reg, res_badr_reg, res_oor_reg};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // shape coefficients
    vsc_coef u_coef (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (coef_start),
        .sphere (sphere_reg),
        .ax     (ax_reg),
        .ay     (ay_reg),
        .az     (az_reg),
        .bx     (bx_reg),
        .by     (by_reg),
        .bz     (bz_reg),
        .done   (coef_done),
        .coef   (coef)
    );

    // voxel scanner
    vsc_scan #(
        .GRID_X (GRID_X),
        .GRID_Y (GRID_Y),
        .GRID_Z (GRID_Z)
    ) u_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (scan_start),
        .cmd     (cmd_reg),
        .coef    (coef),
        .done    (scan_done),
        .we_on   (we_on),
        .we_col  (we_col),
        .on_data (on_wdata),
        .waddr   (waddr)
    );

    // color written by put, zero during the clearing sweep
    assign col_wdata = cmd_reg.clear ? 32'd0 : {alpha_reg, blue_reg, green_reg, red_reg};

    // on bits; cut touches only this store so the color is kept
    vsc_ram #(
        .WIDTH (1),
        .DEPTH (DEPTH)
    ) u_on_ram (
        .clk   (clk),
        .we    (we_on),
        .waddr (waddr),
        .wdata (on_wdata),
        .raddr (rd_addr_reg),
        .rdata (on_rdata)
    );

    // voxel colors, alpha in the top byte
    vsc_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_color_ram (
        .clk   (clk),
        .we    (we_col),
        .waddr (waddr),
        .wdata (col_wdata),
        .raddr (rd_addr_reg),
        .rdata (col_rdata)
    );

endmodule

FILE: src/vsc_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module vsc_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/vsc_coef.sv
// coefficient unit: computes the radius weights, the limit and the per axis
// forward difference seeds with a shared squarer and weight multipliers; uses vsc_pkg
module vsc_coef (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               sphere,
    input  logic signed [9:0]  ax,
    input  logic signed [9:0]  ay,
    input  logic signed [9:0]  az,
    input  logic signed [9:0]  bx,
    input  logic signed [9:0]  by,
    input  logic signed [9:0]  bz,
    output logic               done,
    output vsc_pkg::coef_t     coef
);

    localparam logic [3:0] STEP_PZ  = 4'd0;
    localparam logic [3:0] STEP_PY  = 4'd1;
    localparam logic [3:0] STEP_WX  = 4'd2;
    localparam logic [3:0] STEP_WY  = 4'd3;
    localparam logic [3:0] STEP_WZ  = 4'd4;
    localparam logic [3:0] STEP_LIM = 4'd5;
    localparam logic [3:0] STEP_SX0 = 4'd6;
    localparam logic [3:0] STEP_SX1 = 4'd7;
    localparam logic [3:0] STEP_SY0 = 4'd8;
    localparam logic [3:0] STEP_SY1 = 4'd9;
    localparam logic [3:0] STEP_SZ0 = 4'd10;
    localparam logic [3:0] STEP_SZ1 = 4'd11;

    localparam logic [1:0] PH_SQ  = 2'd0;
    localparam logic [1:0] PH_LO  = 2'd1;
    localparam logic [1:0] PH_HI  = 2'd2;
    localparam logic [1:0] PH_SUM = 2'd3;

    localparam int WW  = vsc_pkg::WW;
    localparam int MW  = vsc_pkg::MW;
    localparam int SW  = vsc_pkg::SW;
    localparam int BLO = vsc_pkg::BLO;
    localparam int SQW = vsc_pkg::SQW;
    localparam int PW  = SQW + BLO;

    logic              active_reg;
    logic [3:0]        step_reg;
    logic [1:0]        phase_reg;
    logic              done_reg;

    logic [SQW-1:0]    asq_reg;
    logic [PW-1:0]     prod_reg;
    logic [PW-1:0]     acc_reg;
    logic [WW-1:0]     pz_reg, py_reg, wx_reg, wy_reg, wz_reg;
    logic [MW-1:0]     lim_reg;
    logic [MW-1:0]     sx0_reg, sx1_reg, sy0_reg, sy1_reg, sz0_reg, sz1_reg;

    logic signed [10:0] v_sel;
    logic [WW-1:0]      b_sel;
    logic signed [21:0] sq_full;
    logic [PW-1:0]      prod_lo, prod_hi;
    logic [MW-1:0]      result;

    // operand selection per step: squared value times weight
    always_comb
    begin
        case (step_reg)
            STEP_PZ:  begin v_sel = {bz[9], bz}; b_sel = WW'(1); end
            STEP_PY:  begin v_sel = {by[9], by}; b_sel = WW'(1); end
            STEP_WX:  begin v_sel = {by[9], by}; b_sel = pz_reg; end
            STEP_WY:  begin v_sel = {bx[9], bx}; b_sel = pz_reg; end
            STEP_WZ:  begin v_sel = {bx[9], bx}; b_sel = py_reg; end
            STEP_LIM: begin v_sel = {bx[9], bx}; b_sel = wx_reg; end
            STEP_SX0: begin v_sel = {ax[9], ax}; b_sel = wx_reg; end
            STEP_SX1: begin v_sel = 11'sd1 - {ax[9], ax}; b_sel = wx_reg; end
            STEP_SY0: begin v_sel = {ay[9], ay}; b_sel = wy_reg; end
            STEP_SY1: begin v_sel = 11'sd1 - {ay[9], ay}; b_sel = wy_reg; end
            STEP_SZ0: begin v_sel = {az[9], az}; b_sel = wz_reg; end
            STEP_SZ1: begin v_sel = 11'sd1 - {az[9], az}; b_sel = wz_reg; end
            default:  begin v_sel = '0; b_sel = '0; end
        endcase
    end

    // shared multipliers, weight split into a low and a high half
    assign sq_full = v_sel * v_sel;
    assign prod_lo = PW'(asq_reg) * PW'(b_sel[BLO-1:0]);
    assign prod_hi = PW'(asq_reg) * PW'(b_sel[WW-1:BLO]);
    assign result  = MW'(acc_reg) + (MW'(prod_reg) << BLO);

    // step and phase sequencing
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            step_reg   <= STEP_PZ;
            phase_reg  <= PH_SQ;
            done_reg   <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                active_reg <= 1'b1;
                step_reg   <= STEP_PZ;
                phase_reg  <= PH_SQ;
            end
            else if (active_reg)
            begin
                phase_reg <= phase_reg + 2'd1;
                if (phase_reg == PH_SUM)
                begin
                    step_reg <= step_reg + 4'd1;
                    if (step_reg == STEP_SZ1)
                    begin
                        active_reg <= 1'b0;
                        done_reg   <= 1'b1;
                    end
                end
            end
        end
    end

    // multiplier pipeline and result storage
    always_ff @(posedge clk)
    begin
        if (active_reg)
        begin
            unique case (phase_reg)
                PH_SQ:  asq_reg <= sq_full[SQW-1:0];
                PH_LO:  prod_reg <= prod_lo;
                PH_HI:
                begin
                    acc_reg  <= prod_reg;
                    prod_reg <= prod_hi;
                end
                PH_SUM:
                begin
                    case (step_reg)
                        STEP_PZ:  pz_reg <= result[WW-1:0];
                        STEP_PY:  py_reg <= result[WW-1:0];
                        STEP_WX:  wx_reg <= sphere ? WW'(1) : result[WW-1:0];
                        STEP_WY:  wy_reg <= sphere ? WW'(1) : result[WW-1:0];
                        STEP_WZ:  wz_reg <= sphere ? WW'(1) : result[WW-1:0];
                        STEP_LIM: lim_reg <= result;
                        STEP_SX0: sx0_reg <= result;
                        STEP_SX1: sx1_reg <= result;
                        STEP_SY0: sy0_reg <= result;
                        STEP_SY1: sy1_reg <= result;
                        STEP_SZ0: sz0_reg <= result;
                        STEP_SZ1: sz1_reg <= result;
                        default:  lim_reg <= lim_reg;
                    endcase
                end
            endcase
        end
    end

    // seeds: value at index 0, first difference, second difference
    assign coef.lim = $signed({{(SW-MW){1'b0}}, lim_reg});
    assign coef.sx0 = $signed({{(SW-MW){1'b0}}, sx0_reg});
    assign coef.dx0 = $signed({{(SW-MW){1'b0}}, sx1_reg})
                    - $signed({{(SW-MW){1'b0}}, sx0_reg});
    assign coef.twx = $signed({{(SW-WW-1){1'b0}}, wx_reg, 1'b0});
    assign coef.sy0 = $signed({{(SW-MW){1'b0}}, sy0_reg});
    assign coef.dy0 = $signed({{(SW-MW){1'b0}}, sy1_reg})
                    - $signed({{(SW-MW){1'b0}}, sy0_reg});
    assign coef.twy = $signed({{(SW-WW-1){1'b0}}, wy_reg, 1'b0});
    assign coef.sz0 = $signed({{(SW-MW){1'b0}}, sz0_reg});
    assign coef.dz0 = $signed({{(SW-MW){1'b0}}, sz1_reg})
                    - $signed({{(SW-MW){1'b0}}, sz0_reg});
    assign coef.twz = $signed({{(SW-WW-1){1'b0}}, wz_reg, 1'b0});

    assign done = done_reg;

endmodule

FILE: src/vsc_scan.sv
// voxel scanner: walks an index box one voxel a cycle, evaluates the shape
// test by forward differences and drives the store write port; uses vsc_pkg
module vsc_scan #(
    parameter int GRID_X = 32,
    parameter int GRID_Y = 32,
    parameter int GRID_Z = 32
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  vsc_pkg::scan_cmd_t        cmd,
    input  vsc_pkg::coef_t            coef,
    output logic                      done,
    output logic                      we_on,
    output logic                      we_col,
    output logic                      on_data,
    output logic [((GRID_X*GRID_Y*GRID_Z > 1) ?
                   $clog2(GRID_X*GRID_Y*GRID_Z) : 1)-1:0] waddr
);

    localparam int DEPTH = GRID_X * GRID_Y * GRID_Z;
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int XW = (GRID_X > 1) ? $clog2(GRID_X) : 1;
    localparam int YW = (GRID_Y > 1) ? $clog2(GRID_Y) : 1;
    localparam int ZW = (GRID_Z > 1) ? $clog2(GRID_Z) : 1;
    localparam int YZ = GRID_Y * GRID_Z;
    localparam int SW = vsc_pkg::SW;

    logic                 run_reg;
    logic [XW-1:0]        i_reg;
    logic [YW-1:0]        j_reg;
    logic [ZW-1:0]        k_reg;
    logic                 b_valid_reg;
    logic                 b_last_reg;
    logic signed [SW-1:0] sx_reg, dx_reg, sy_reg, dy_reg, sz_reg, dz_reg;
    logic signed [SW-1:0] sum_reg;
    logic [AW-1:0]        addr_reg;

    logic                 k_end, j_end, i_end, last_now;
    logic [AW-1:0]        addr_calc;
    logic                 hit;

    assign k_end    = (k_reg == cmd.zhi[ZW-1:0]);
    assign j_end    = (j_reg == cmd.yhi[YW-1:0]);
    assign i_end    = (i_reg == cmd.xhi[XW-1:0]);
    assign last_now = k_end && j_end && i_end;

    assign addr_calc = AW'(i_reg) * AW'(YZ) + AW'(j_reg) * AW'(GRID_Z) + AW'(k_reg);

    // index counters, z innermost
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg     <= 1'b0;
            i_reg       <= '0;
            j_reg       <= '0;
            k_reg       <= '0;
            b_valid_reg <= 1'b0;
            b_last_reg  <= 1'b0;
        end
        else
        begin
            b_valid_reg <= run_reg;
            b_last_reg  <= run_reg && last_now;
            if (start)
            begin
                run_reg <= 1'b1;
                i_reg   <= cmd.xlo[XW-1:0];
                j_reg   <= cmd.ylo[YW-1:0];
                k_reg   <= cmd.zlo[ZW-1:0];
            end
            else if (run_reg)
            begin
                priority if (!k_end)
                begin
                    k_reg <= k_reg + ZW'(1);
                end
                else if (!j_end)
                begin
                    k_reg <= cmd.zlo[ZW-1:0];
                    j_reg <= j_reg + YW'(1);
                end
                else if (!i_end)
                begin
                    k_reg <= cmd.zlo[ZW-1:0];
                    j_reg <= cmd.ylo[YW-1:0];
                    i_reg <= i_reg + XW'(1);
                end
                else
                begin
                    run_reg <= 1'b0;
                end
            end
        end
    end

    // forward differences of the weighted squared offsets
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            sx_reg <= coef.sx0;
            dx_reg <= coef.dx0;
            sy_reg <= coef.sy0;
            dy_reg <= coef.dy0;
            sz_reg <= coef.sz0;
            dz_reg <= coef.dz0;
        end
        else if (run_reg)
        begin
            if (!k_end)
            begin
                sz_reg <= sz_reg + dz_reg;
                dz_reg <= dz_reg + coef.twz;
            end
            else
            begin
                sz_reg <= coef.sz0;
                dz_reg <= coef.dz0;
                if (!j_end)
                begin
                    sy_reg <= sy_reg + dy_reg;
                    dy_reg <= dy_reg + coef.twy;
                end
                else
                begin
                    sy_reg <= coef.sy0;
                    dy_reg <= coef.dy0;
                    sx_reg <= sx_reg + dx_reg;
                    dx_reg <= dx_reg + coef.twx;
                end
            end
        end
    end

    // first stage: sum and address
    always_ff @(posedge clk)
    begin
        sum_reg  <= sx_reg + sy_reg + sz_reg;
        addr_reg <= addr_calc;
    end

    // second stage: compare and write
    assign hit     = !cmd.test || (sum_reg <= coef.lim);
    assign we_on   = b_valid_reg && hit;
    assign we_col  = we_on && (cmd.put || cmd.clear);
    assign on_data = cmd.put;
    assign waddr   = addr_reg;
    assign done    = b_valid_reg && b_last_reg;

endmodule
